>>> rtl/signed_int_to_decimal_ascii_defines.svh
// Assertion macros for the signed integer to decimal text converter.
// Included by the top level; no other dependencies.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication under an active-low reset.
`define SIDA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication under an active-low reset.
`define SIDA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define SIDA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SIDA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/sida_pkg.sv
// Shared types and constants for the signed integer to decimal text converter.
// No dependencies.
`timescale 1ns / 1ps

package sida_pkg;

    // ASCII codes used on the output.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // Capture a new value and clear the digit register.
        logic dabble;      // One shift-and-add-3 step of the binary to BCD conversion.
        logic shift_digit; // Drop the leading digit and move the next one up.
        logic sel_sign;    // Present the minus sign instead of a digit.
    } sida_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic conv_last;   // The current dabble step is the final one.
        logic top_zero;    // The leading digit is zero.
        logic last_digit;  // Only one digit remains.
        logic negative;    // The captured value is negative.
    } sida_status_t;

endpackage

>>> rtl/sida_datapath.sv
// Datapath: magnitude register, BCD digit register, step and digit counters.
// Depends on sida_pkg.
`timescale 1ns / 1ps

module sida_datapath
    import sida_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [VALUE_BITS-1:0] value,
    input  sida_cmd_t             cmd,
    output sida_status_t          status,
    output logic [7:0]            char_out,
    output logic                  last_char
);

    // Enough decimal digits for any VALUE_BITS-bit unsigned magnitude.
    localparam int DIGITS      = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int BCD_W       = DIGITS * 4;
    localparam int BIT_CNT_W   = $clog2(VALUE_BITS);
    localparam int DIGIT_CNT_W = $clog2(DIGITS + 1);

    logic [VALUE_BITS-1:0]  mag_reg, mag_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic                   neg_reg, neg_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [DIGIT_CNT_W-1:0] digit_cnt_reg, digit_cnt_next;
    logic [BCD_W-1:0]       bcd_adj;
    logic [3:0]             top_digit;

    // Add 3 to every digit of 5 or more before the shift; digits are independent.
    always_comb
    begin
        for (int d = 0; d < DIGITS; d++)
        begin
            if (bcd_reg[d*4 +: 4] >= 4'd5)
                bcd_adj[d*4 +: 4] = bcd_reg[d*4 +: 4] + 4'd3;
            else
                bcd_adj[d*4 +: 4] = bcd_reg[d*4 +: 4];
        end
    end

    // Next-state selection for the datapath registers.
    always_comb
    begin
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        neg_next       = neg_reg;
        bit_cnt_next   = bit_cnt_reg;
        digit_cnt_next = digit_cnt_reg;
        if (cmd.load)
        begin
            neg_next       = value[VALUE_BITS-1];
            mag_next       = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
            bcd_next       = '0;
            bit_cnt_next   = '0;
            digit_cnt_next = DIGIT_CNT_W'(DIGITS);
        end
        else if (cmd.dabble)
        begin
            bcd_next     = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_BITS-1]};
            mag_next     = {mag_reg[VALUE_BITS-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + 1'b1;
        end
        else if (cmd.shift_digit)
        begin
            bcd_next       = {bcd_reg[BCD_W-5:0], 4'd0};
            digit_cnt_next = digit_cnt_reg - 1'b1;
        end
    end

    // Control counters are reset; the payload registers are not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg   <= '0;
            digit_cnt_reg <= '0;
        end
        else
        begin
            bit_cnt_reg   <= bit_cnt_next;
            digit_cnt_reg <= digit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

    // Status and the character word.
    assign top_digit         = bcd_reg[BCD_W-1 -: 4];
    assign status.conv_last  = (bit_cnt_reg == BIT_CNT_W'(VALUE_BITS - 1));
    assign status.top_zero   = (top_digit == 4'd0);
    assign status.last_digit = (digit_cnt_reg == DIGIT_CNT_W'(1));
    assign status.negative   = neg_reg;
    assign char_out          = cmd.sel_sign ? CH_MINUS : (CH_ZERO | {4'd0, top_digit});
    assign last_char         = !cmd.sel_sign && status.last_digit;

endmodule

>>> rtl/sida_controller.sv
// Controller state machine: sequences capture, conversion, zero skipping and output.
// Depends on sida_pkg.
`timescale 1ns / 1ps

module sida_controller
    import sida_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  sida_status_t status,
    output sida_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;
    logic   valid_reg, valid_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.dabble = 1'b1;
                if (status.conv_last)
                    state_next = ST_SKIP;
            end
            ST_SKIP:
            begin
                if (status.top_zero && !status.last_digit)
                    cmd.shift_digit = 1'b1;
                else if (status.negative)
                    state_next = ST_SIGN;
                else
                    state_next = ST_EMIT;
            end
            ST_SIGN:
            begin
                cmd.sel_sign = 1'b1;
                if (out_ready)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    if (status.last_digit)
                        state_next = ST_IDLE;
                    else
                        cmd.shift_digit = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        ready_next = (state_next == ST_IDLE);
        valid_next = (state_next == ST_SIGN) || (state_next == ST_EMIT);
    end

    // State and registered handshake outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = ready_reg;
    assign out_valid = valid_reg;

endmodule

>>> rtl/signed_int_to_decimal_ascii.sv
// Top level of the signed integer to decimal ASCII text converter.
// Depends on sida_pkg, sida_controller, sida_datapath and the defines header.
//
//   Channel   Direction  Word
//   s_axis    in         tdata: value (VALUE_BITS bits, signed), padded to bytes, padding ignored
//   m_axis    out        tdata: char_out (8 bits); tlast: last_char
//
// One word is accepted, converted by VALUE_BITS shift-and-add-3 steps, has its
// leading zero digits skipped in the skip state, then has its characters emitted.
// Skipped zeros and digits always total ten for 32 bits, with a leading minus
// sign emitted first when the value is negative.
// Reset clears the controller and counters only; no memory needs clearing.
// A stall on the output holds the current character; no new word is taken until
// the last character of the current one has been delivered.
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_defines.svh"

module signed_int_to_decimal_ascii
    import sida_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_tdata,  // [VALUE_BITS-1:0] value
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [7:0]                            m_tdata,  // [7:0] char_out
    output logic                                  m_tlast
);

    sida_cmd_t    cmd;
    sida_status_t status;

    // Sequencer.
    sida_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // Conversion registers.
    sida_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (s_tdata[VALUE_BITS-1:0]),
        .cmd       (cmd),
        .status    (status),
        .char_out  (m_tdata),
        .last_char (m_tlast)
    );

    // Input and output sides are never open at the same time.
    `SIDA_ASSERT_IMP(a_ready_excl_valid, clk, rst_n, s_tready, !m_tvalid)
    // Delivering the final character returns the block to accepting input.
    `SIDA_ASSERT_NXT(a_last_frees_input, clk, rst_n, m_tvalid && m_tready && m_tlast, s_tready)
    // A captured word needs conversion before any character appears.
    `SIDA_ASSERT_NXT(a_accept_then_busy, clk, rst_n, s_tvalid && s_tready, !m_tvalid && !s_tready)
    // Every character is a minus sign or a decimal digit.
    `SIDA_ASSERT_IMP(a_char_legal, clk, rst_n, m_tvalid,
        (m_tdata == CH_MINUS) || ((m_tdata >= CH_ZERO) && (m_tdata <= CH_NINE)))

endmodule

>>> bench/signed_int_to_decimal_ascii_test.sv
// Self-checking bench for signed_int_to_decimal_ascii: drives signed integers on the
// input stream and checks each emitted character and its last flag against a predictor.
// Depends on sida_pkg and the signed_int_to_decimal_ascii top level.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_test;
    import sida_pkg::*;

    localparam int VALUE_BITS = 32;
    localparam int TDATA_W = ((VALUE_BITS + 7) / 8) * 8;
    localparam logic [TDATA_W-1:0] VALUE_MASK = TDATA_W'({VALUE_BITS{1'b1}});
    localparam longint MAX_VALUE = (longint'(1) <<< (VALUE_BITS - 1)) - 1;
    localparam longint MIN_VALUE = -(longint'(1) <<< (VALUE_BITS - 1));
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam int CALM_WORDS = 40;
    localparam int HOLD_AT_WORD = 60;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_WORDS = 255;

    typedef struct {
        logic [7:0] char_out;
        logic       last_char;
    } char_word_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;   // [VALUE_BITS-1:0] value
    logic               m_tvalid;
    logic               m_tready;
    logic [7:0]         m_tdata;   // [7:0] char_out
    logic               m_tlast;

    logic [TDATA_W-1:0] pending_values[$];
    char_word_t         expected_chars[$];
    int                 item_total;
    int                 words_taken;
    int                 chars_seen;
    int                 failures;
    int                 cycle_count;
    int                 src_gap;
    int                 src_idle_pct;
    int                 sink_gap;
    int                 sink_idle_pct;
    int                 hold_left;
    logic               hold_armed;
    logic               calm;

    signed_int_to_decimal_ascii #(
        .VALUE_BITS(VALUE_BITS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Works out the characters of one value: optional sign, then digits, most
    // significant first, with the flag on the final one. Bits above the width drop out.
    function automatic void predict_decimal_text(input logic [TDATA_W-1:0] word);
        logic [VALUE_BITS-1:0] raw;
        logic [VALUE_BITS-1:0] mag;
        logic                  negative;
        logic [7:0]            digits[$];
        char_word_t            ch;
        raw = word[VALUE_BITS-1:0];
        negative = raw[VALUE_BITS-1];
        // The unsigned magnitude holds the most negative value without overflow.
        mag = negative ? (~raw + 1'b1) : raw;
        do
        begin
            digits.push_front(CH_ZERO + 8'(mag % 10));
            mag = mag / 10;
        end
        while (mag != 0);
        if (negative)
        begin
            ch.char_out = CH_MINUS;
            ch.last_char = 1'b0;
            expected_chars.push_back(ch);
        end
        foreach (digits[i])
        begin
            ch.char_out = digits[i];
            ch.last_char = (i == digits.size() - 1);
            expected_chars.push_back(ch);
        end
    endfunction

    // Queues one value; padding bits above the value width get random contents.
    function automatic void queue_value(input longint v);
        logic [TDATA_W-1:0] noise;
        noise = TDATA_W'({$urandom, $urandom});
        pending_values.push_back((TDATA_W'(v) & VALUE_MASK) | (noise & ~VALUE_MASK));
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 30;
            default: return 70;
        endcase
    endfunction

    assign calm = (words_taken >= item_total - CALM_WORDS);

    // Input driver: offers pending words, predicts each accepted one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            words_taken <= 0;
            src_gap <= 0;
            src_idle_pct <= 30;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
            begin
                predict_decimal_text(s_tdata);
                words_taken <= words_taken + 1;
                if (words_taken % 32 == 31)
                begin
                    src_idle_pct <= pick_idle_pct();
                end
            end
            if (src_gap != 0)
            begin
                s_tvalid <= 1'b0;
                src_gap <= src_gap - 1;
            end
            else if (pending_values.size() != 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_values.pop_front();
                if (!calm && $urandom_range(0, 99) < src_idle_pct)
                begin
                    src_gap <= $urandom_range(1, 7);
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // One long receiver hold-off so the block fills and stalls its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_armed <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (hold_armed && words_taken == HOLD_AT_WORD)
        begin
            hold_left <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end
    end

    // Output monitor: checks each delivered character and throttles ready.
    always @(posedge clk or negedge rst_n)
    begin
        char_word_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            sink_gap <= 0;
            sink_idle_pct <= 30;
            chars_seen <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                chars_seen <= chars_seen + 1;
                if (chars_seen % 40 == 39)
                begin
                    sink_idle_pct <= pick_idle_pct();
                end
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected character: char_out %h, last_char %b", m_tdata, m_tlast);
                    failures++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (m_tdata !== want.char_out)
                    begin
                        $error("char_out mismatch: expected %h, actual %h",
                               want.char_out, m_tdata);
                        failures++;
                    end
                    if (m_tlast !== want.last_char)
                    begin
                        $error("last_char mismatch: expected %b, actual %b",
                               want.last_char, m_tlast);
                        failures++;
                    end
                end
            end
            if (hold_left != 0)
            begin
                m_tready <= 1'b0;
            end
            else if (sink_gap != 0)
            begin
                m_tready <= 1'b0;
                sink_gap <= sink_gap - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < sink_idle_pct)
                begin
                    sink_gap <= $urandom_range(1, 7);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        longint v;
        longint lo;
        longint hi;
        longint unsigned span;
        int k;
        failures = 0;
        cycle_count = 0;
        item_total = 0;
        rst_n = 1'b0;

        // Directed values: zero, single digits, decade boundaries, extremes.
        queue_value(0);
        queue_value(1);
        queue_value(-1);
        queue_value(9);
        queue_value(-9);
        queue_value(10);
        queue_value(-10);
        queue_value(99);
        queue_value(100);
        queue_value(999999999);
        queue_value(1000000000);
        queue_value(-1000000000);
        queue_value(123456789);
        queue_value(-987654321);
        queue_value(MAX_VALUE);
        queue_value(MIN_VALUE);
        queue_value(MIN_VALUE + 1);
        queue_value(MAX_VALUE - 1);
        queue_value(32'sh55555555);
        queue_value(longint'(32'shAAAAAAAA));

        // Random values: mostly spread over digit counts, some raw bit patterns,
        // some near the extremes and near zero.
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            k = $urandom_range(0, 99);
            if (k < 60)
            begin
                lo = 1;
                for (int d = $urandom_range(1, 10); d > 1; d--)
                begin
                    lo = lo * 10;
                end
                hi = lo * 10 - 1;
                if (lo == 1)
                begin
                    lo = 0;
                end
                if (hi > MAX_VALUE)
                begin
                    hi = MAX_VALUE;
                end
                span = longint'(hi - lo + 1);
                v = lo + longint'({$urandom, $urandom} % span);
                if ($urandom_range(0, 1))
                begin
                    v = -v;
                end
            end
            else if (k < 90)
            begin
                v = longint'(signed'($urandom));
            end
            else if (k < 94)
            begin
                v = MIN_VALUE + $urandom_range(0, 20);
            end
            else if (k < 97)
            begin
                v = MAX_VALUE - $urandom_range(0, 20);
            end
            else
            begin
                v = longint'($urandom_range(0, 40)) - 20;
            end
            queue_value(v);
        end
        item_total = pending_values.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (words_taken < item_total)
        begin
            @(posedge clk);
        end
        while (expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
